### rtl/asdc_pkg.sv
`timescale 1ns / 1ps

package asdc_pkg;

  // width of the command-age counter (8 to 32)
  localparam int unsigned AGE_WIDTH = 16;

  localparam int unsigned PulseW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RptW    = 16;

  localparam logic [CfgW-1:0] TimeoutRst  = 16'd200;
  localparam logic [CfgW-1:0] PulseMinRst = 16'd500;
  localparam logic [CfgW-1:0] PulseMaxRst = 16'd2500;
  localparam logic [RptW-1:0] RptMax      = 16'd65535;

  typedef enum logic [2:0] {
    CMD_ARM        = 3'd0,
    CMD_SAFE       = 3'd1,
    CMD_SET_PULSE  = 3'd2,
    CMD_KEEPALIVE  = 3'd3,
    CMD_UNKNOWN    = 3'd4,
    CMD_TICK       = 3'd5,
    CMD_CONNECT    = 3'd6,
    CMD_DISCONNECT = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_FAULT    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ERR_CLEAR   = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_DEADMAN = 2'd2
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_PULSE_MIN = 2'd1,
    CFG_PULSE_MAX = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] timeout_ms;
    logic [CfgW-1:0] pulse_min_us;
    logic [CfgW-1:0] pulse_max_us;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [PulseW-1:0] req_width;
    logic              length_ok;
  } item_t;

  typedef struct packed {
    mode_e             mode;
    err_e              fault_code;
    logic              drive_update;
    logic [PulseW-1:0] drive_pulse_us;
    logic [RptW-1:0]   cmd_age_ms;
  } result_t;

endpackage

### rtl/asdc_cfg_regs.sv
`timescale 1ns / 1ps

module asdc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asdc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [asdc_pkg::CfgW-1:0]       cfg_data_i,
  output asdc_pkg::cfg_t                  cfg_o
);
  import asdc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT:   cfg_d.timeout_ms   = cfg_data_i;
        CFG_PULSE_MIN: cfg_d.pulse_min_us = cfg_data_i;
        CFG_PULSE_MAX: cfg_d.pulse_max_us = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ms   <= TimeoutRst;
      cfg_q.pulse_min_us <= PulseMinRst;
      cfg_q.pulse_max_us <= PulseMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/asdc_core.sv
`timescale 1ns / 1ps

module asdc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  asdc_pkg::item_t   item_i,
  input  asdc_pkg::cfg_t    cfg_i,
  output asdc_pkg::result_t res_o
);
  import asdc_pkg::*;

  localparam int unsigned AgeExtW = (AGE_WIDTH > RptW) ? AGE_WIDTH : RptW;
  localparam logic [AGE_WIDTH-1:0] AgeMax = {AGE_WIDTH{1'b1}};

  mode_e                mode_q, mode_d;
  err_e                 err_q, err_d;
  logic [AGE_WIDTH-1:0] age_q, age_d;
  logic                 age_vld_q, age_vld_d;

  logic [AGE_WIDTH-1:0] age_inc;
  logic [AgeExtW-1:0]   age_ext;
  logic [RptW-1:0]      age_rpt;
  logic [PulseW-1:0]    pulse_clamped;
  logic                 upd;
  logic [PulseW-1:0]    drv;

  // min is checked first: with crossed limits a width below min gets min, one above both gets max
  always_comb begin
    if (item_i.req_width < cfg_i.pulse_min_us) begin
      pulse_clamped = cfg_i.pulse_min_us;
    end else if (item_i.req_width > cfg_i.pulse_max_us) begin
      pulse_clamped = cfg_i.pulse_max_us;
    end else begin
      pulse_clamped = item_i.req_width;
    end
  end

  // saturating count only while the age is valid
  assign age_inc = (age_vld_q && age_q != AgeMax) ? age_q + 1'b1 : age_q;

  always_comb begin
    mode_d    = mode_q;
    err_d     = err_q;
    age_d     = age_q;
    age_vld_d = age_vld_q;
    upd       = 1'b0;
    drv       = '0;
    unique case (item_i.cmd)
      CMD_ARM: begin
        if (mode_q != MODE_ARMED) begin
          mode_d    = MODE_ARMED;
          err_d     = ERR_CLEAR;
          age_d     = '0;
          age_vld_d = 1'b1;
        end
      end
      CMD_SAFE: begin
        mode_d    = MODE_DISARMED;
        err_d     = ERR_CLEAR;
        age_d     = '0;
        age_vld_d = 1'b0;
        upd       = 1'b1;
      end
      CMD_SET_PULSE: begin
        if (item_i.length_ok && mode_q == MODE_ARMED) begin
          age_d     = '0;
          age_vld_d = 1'b1;
          upd       = 1'b1;
          drv       = pulse_clamped;
        end
      end
      CMD_KEEPALIVE: begin
        if (mode_q == MODE_ARMED) begin
          age_d     = '0;
          age_vld_d = 1'b1;
        end
      end
      CMD_UNKNOWN: begin
        err_d = ERR_INVALID;
      end
      CMD_TICK: begin
        age_d = age_inc;
      end
      CMD_CONNECT: begin
        mode_d    = MODE_DISARMED;
        err_d     = ERR_CLEAR;
        age_d     = '0;
        age_vld_d = 1'b0;
      end
      CMD_DISCONNECT: begin
        mode_d = MODE_FAULT;
        err_d  = ERR_CLEAR;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    // deadman check uses the age after this tick
    age_ext = AgeExtW'(age_d);
    if (!age_vld_d) begin
      age_rpt = '0;
    end else if (age_ext > AgeExtW'(RptMax)) begin
      age_rpt = RptMax;
    end else begin
      age_rpt = age_ext[RptW-1:0];
    end

    if (item_i.cmd == CMD_TICK && mode_q == MODE_ARMED && age_rpt >= cfg_i.timeout_ms) begin
      mode_d = MODE_FAULT;
      err_d  = ERR_DEADMAN;
      upd    = 1'b1;
      drv    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_DISARMED;
      err_q     <= ERR_CLEAR;
      age_q     <= '0;
      age_vld_q <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      err_q     <= err_d;
      age_q     <= age_d;
      age_vld_q <= age_vld_d;
    end
  end

  assign res_o.mode           = mode_d;
  assign res_o.fault_code     = err_d;
  assign res_o.drive_update   = upd;
  assign res_o.drive_pulse_us = drv;
  assign res_o.cmd_age_ms     = age_rpt;

  a_invalid_age_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !age_vld_q |-> age_q == '0)
    else $error("age counter non-zero while invalid");

  a_armed_age_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ARMED |-> age_vld_q)
    else $error("armed without a valid command age");

  a_disarm_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == CMD_SAFE |=> mode_q == MODE_DISARMED && !age_vld_q)
    else $error("disarm did not clear mode and age");

  a_deadman_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.cmd == CMD_TICK && mode_q == MODE_ARMED && mode_d == MODE_FAULT
    |-> upd && drv == '0 && err_d == ERR_DEADMAN)
    else $error("deadman fault without drive stop");

endmodule

### rtl/armed_servo_deadman_controller.sv
`timescale 1ns / 1ps

// safety arm/disarm controller for one servo channel. each input item is one
// decoded command (in tuser) with its pulse payload (in tdata); every item
// gives exactly one result item carrying the mode, error code, drive write
// and command age after that command. an item enters an input register, the
// controller state is updated in one pass of compare-and-select logic, and
// the result lands in an output register, so one item is taken every clock
// cycle while the downstream is ready; its result is offered once it has passed
// the input register and then the output register. a full output register
// only stalls the input side when the downstream is not ready. the user must
// write the three limits through the plain config port while idle (unchecked).
module armed_servo_deadman_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [asdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [asdc_pkg::CfgW-1:0]     cfg_data_i,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] req_width
  input  logic [3:0]                    s_axis_tuser,  // [2:0] cmd, [3] length_ok
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] mode, [3:2] fault_code, [4] drive_update, [20:5] drive_pulse_us,
  // [36:21] cmd_age_ms, [39:37] zero
  output logic [39:0]                   m_axis_tdata
);
  import asdc_pkg::*;

  cfg_t    cfg;
  item_t   in_q, in_d;
  logic    in_vld_q;
  result_t res;
  result_t out_q;
  logic    out_vld_q;
  logic    advance;

  asdc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // an item moves on when the output register is free or being emptied
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  assign in_d.cmd       = cmd_e'(s_axis_tuser[2:0]);
  assign in_d.length_ok = s_axis_tuser[3];
  assign in_d.req_width = s_axis_tdata;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  asdc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_q.cmd_age_ms, out_q.drive_pulse_us,
                          out_q.drive_update, out_q.fault_code, out_q.mode};

endmodule

### sim/asdc_checker.sv
`timescale 1ns / 1ps

module asdc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [asdc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [asdc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [15:0] req_width
  input  logic [3:0]                   s_axis_tuser,   // [2:0] cmd, [3] length_ok
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [1:0] mode, [3:2] fault_code, [4] drive_update, [20:5] drive_pulse_us,
  // [36:21] cmd_age_ms, [39:37] zero
  input  logic [39:0]                  m_axis_tdata,
  output int unsigned                  fails_o,
  output int unsigned                  pending_o
);
  import asdc_pkg::*;

  logic [CfgW-1:0]      timeout_lim;
  logic [CfgW-1:0]      pulse_lo;
  logic [CfgW-1:0]      pulse_hi;

  mode_e                mode_now;
  err_e                 err_now;
  logic [AGE_WIDTH-1:0] age_cnt;
  logic                 age_live;

  result_t              status_due[$];
  int unsigned          mismatches;

  function automatic logic [RptW-1:0] shown_age();
    if (!age_live) return '0;
    if (age_cnt > RptMax) return RptMax;
    return RptW'(age_cnt);
  endfunction

  task automatic restart_age();
    age_cnt  = '0;
    age_live = 1'b1;
  endtask

  task automatic clear_age();
    age_cnt  = '0;
    age_live = 1'b0;
  endtask

  task automatic predict_status(input cmd_e cmd, input logic [PulseW-1:0] pulse,
                                input logic len_ok);
    result_t           r;
    logic [PulseW-1:0] p;
    r = '0;
    case (cmd)
      CMD_ARM: begin
        if (mode_now != MODE_ARMED) begin
          mode_now = MODE_ARMED;
          err_now  = ERR_CLEAR;
          restart_age();
        end
      end
      CMD_SAFE: begin
        mode_now = MODE_DISARMED;
        err_now  = ERR_CLEAR;
        clear_age();
        r.drive_update = 1'b1;
      end
      CMD_SET_PULSE: begin
        if (len_ok && mode_now == MODE_ARMED) begin
          restart_age();
          p = pulse;
          // with crossed limits, a width below the lower clamp gets it, one above both the upper
          if (p < pulse_lo) p = pulse_lo;
          else if (p > pulse_hi) p = pulse_hi;
          r.drive_update   = 1'b1;
          r.drive_pulse_us = p;
        end
      end
      CMD_KEEPALIVE: begin
        if (mode_now == MODE_ARMED) restart_age();
      end
      CMD_UNKNOWN: begin
        err_now = ERR_INVALID;
      end
      CMD_TICK: begin
        if (age_live && age_cnt != '1) age_cnt = age_cnt + 1'b1;
        if (mode_now == MODE_ARMED && shown_age() >= timeout_lim) begin
          mode_now = MODE_FAULT;
          err_now  = ERR_DEADMAN;
          r.drive_update = 1'b1;
        end
      end
      CMD_CONNECT: begin
        mode_now = MODE_DISARMED;
        err_now  = ERR_CLEAR;
        clear_age();
      end
      default: begin
        mode_now = MODE_FAULT;
        err_now  = ERR_CLEAR;
      end
    endcase
    r.mode       = mode_now;
    r.fault_code = err_now;
    r.cmd_age_ms = shown_age();
    status_due.push_back(r);
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      timeout_lim = TimeoutRst;
      pulse_lo    = PulseMinRst;
      pulse_hi    = PulseMaxRst;
      mode_now    = MODE_DISARMED;
      err_now     = ERR_CLEAR;
      clear_age();
      status_due.delete();
      mismatches  = 0;
      fails_o     <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT:   timeout_lim = cfg_data_i;
          CFG_PULSE_MIN: pulse_lo    = cfg_data_i;
          CFG_PULSE_MAX: pulse_hi    = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_status(cmd_e'(s_axis_tuser[2:0]), s_axis_tdata, s_axis_tuser[3]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due.size() == 0) begin
          $error("result item with no command waiting: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("mode", want.mode, m_axis_tdata[1:0]);
          check_field("fault_code", want.fault_code, m_axis_tdata[3:2]);
          check_field("drive_update", want.drive_update, m_axis_tdata[4]);
          check_field("drive_pulse_us", want.drive_pulse_us, m_axis_tdata[20:5]);
          check_field("cmd_age_ms", want.cmd_age_ms, m_axis_tdata[36:21]);
        end
      end
      fails_o   <= mismatches;
      pending_o <= status_due.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

// servo arm/disarm controller bench: directed commands first, then random
// phases under several limit settings; a separate checker predicts every
// result item and counts mismatches, this module only drives and judges
module tb;
  import asdc_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;   // [15:0] req_width
  logic [3:0]         s_axis_tuser;   // [2:0] cmd, [3] length_ok
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // [1:0] mode, [3:2] fault_code, [4] drive_update, [20:5] drive_pulse_us,
  // [36:21] cmd_age_ms, [39:37] zero
  logic [39:0]        m_axis_tdata;

  int unsigned        fails;
  int unsigned        pending;

  // calm: neither side idles; hold_go: ask the receiver for one long hold-off
  bit                 calm;
  bit                 hold_go;

  armed_servo_deadman_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  asdc_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fails_o       (fails),
    .pending_o     (pending)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random back-pressure, none while calm, and one long
  // hold-off (counted here) so the block fills up and stalls its input
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (90) @(posedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // offer one item, with random gaps in front of it, and wait for acceptance
  task automatic send_cmd(input cmd_e cmd, input logic [PulseW-1:0] pulse,
                          input logic len_ok);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pulse;
    s_axis_tuser  <= {len_ok, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering and let every predicted result item come back;
  // the first edge lets the checker's count catch up with the last item
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all three limits, only ever called while the block is idle
  task automatic set_limits(input logic [CfgW-1:0] timeout,
                            input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= timeout;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_MIN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_MAX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // starving runs are mostly ticks so the deadman gets a chance to fire;
  // feeding runs keep the channel armed and busy with pulse updates
  function automatic cmd_e pick_cmd(input bit starve);
    int unsigned r;
    r = $urandom_range(99);
    if (starve) begin
      if (r < 85) return CMD_TICK;
      if (r < 90) return CMD_UNKNOWN;
      if (r < 95) return CMD_ARM;
      return cmd_e'($urandom_range(7));
    end
    if (r < 10) return CMD_ARM;
    if (r < 40) return CMD_SET_PULSE;
    if (r < 50) return CMD_KEEPALIVE;
    if (r < 78) return CMD_TICK;
    if (r < 83) return CMD_UNKNOWN;
    if (r < 89) return CMD_SAFE;
    if (r < 94) return CMD_CONNECT;
    return CMD_DISCONNECT;
  endfunction

  // full range, inside the clamp window, or on or just beyond its edges
  function automatic logic [PulseW-1:0] pick_pulse(input logic [CfgW-1:0] lo,
                                                   input logic [CfgW-1:0] hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return PulseW'($urandom_range(65535));
    if (r < 80) return PulseW'($urandom_range(hi, lo));
    case ($urandom_range(3))
      0:       return lo - 1'b1;
      1:       return lo;
      2:       return hi;
      default: return hi + 1'b1;
    endcase
  endfunction

  // random phase; pause_at makes the sender wait for every result mid-phase
  task automatic random_burst(input int unsigned count, input logic [CfgW-1:0] lo,
                              input logic [CfgW-1:0] hi, input int unsigned pause_at);
    int unsigned run_left;
    bit          starve;
    run_left = 0;
    starve   = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      if (run_left == 0) begin
        starve   = ($urandom_range(99) < 35);
        run_left = $urandom_range(40, 16);
      end
      run_left--;
      // a tenth of the items are plain noise
      if ($urandom_range(99) < 10)
        send_cmd(cmd_e'($urandom_range(7)), PulseW'($urandom_range(65535)),
                 1'($urandom_range(1)));
      else
        send_cmd(pick_cmd(starve), pick_pulse(lo, hi), $urandom_range(99) < 85);
    end
  endtask

  initial begin
    logic [CfgW-1:0] t;
    logic [CfgW-1:0] lo;
    logic [CfgW-1:0] hi;

    calm          <= 1'b0;
    hold_go       <= 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_TIMEOUT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the limits as they come out of reset
    send_cmd(CMD_SET_PULSE, 16'd1000, 1'b1);     // ignored while disarmed
    send_cmd(CMD_KEEPALIVE, 16'd0, 1'b0);        // no age to restart yet
    send_cmd(CMD_UNKNOWN, 16'hFFFF, 1'b1);       // invalid command error
    send_cmd(CMD_TICK, 16'd0, 1'b0);             // age not valid, stays 0
    send_cmd(CMD_ARM, 16'd0, 1'b0);
    send_cmd(CMD_ARM, 16'd0, 1'b0);              // already armed, no change
    send_cmd(CMD_SET_PULSE, 16'd0, 1'b1);        // raised to the lower clamp
    send_cmd(CMD_SET_PULSE, 16'hFFFF, 1'b1);     // lowered to the upper clamp
    send_cmd(CMD_SET_PULSE, 16'd1500, 1'b0);     // wrong payload length
    send_cmd(CMD_SET_PULSE, 16'd1500, 1'b1);     // in range, passed through
    send_cmd(CMD_TICK, 16'd0, 1'b0);
    send_cmd(CMD_TICK, 16'd0, 1'b0);
    send_cmd(CMD_KEEPALIVE, 16'd0, 1'b0);        // age restarts while armed
    send_cmd(CMD_DISCONNECT, 16'd0, 1'b0);       // fault, age kept
    send_cmd(CMD_TICK, 16'd0, 1'b0);             // age still counts in fault
    send_cmd(CMD_SET_PULSE, 16'd1234, 1'b1);     // ignored in fault
    send_cmd(CMD_ARM, 16'd0, 1'b0);              // rearm out of fault
    send_cmd(CMD_CONNECT, 16'd0, 1'b0);
    send_cmd(CMD_SAFE, 16'd0, 1'b0);
    send_cmd(CMD_UNKNOWN, 16'd0, 1'b0);
    send_cmd(CMD_ARM, 16'd0, 1'b0);              // arming clears the error
    settle();

    // crossed clamp limits and a zero timeout
    set_limits(16'd0, 16'd3000, 16'd1000);
    send_cmd(CMD_SET_PULSE, 16'd2000, 1'b1);     // below min: min wins
    send_cmd(CMD_SET_PULSE, 16'd4000, 1'b1);     // above both: max applies
    send_cmd(CMD_TICK, 16'd0, 1'b0);             // first tick armed: deadman
    settle();

    // random phases, each under its own limits
    set_limits(TimeoutRst, PulseMinRst, PulseMaxRst);
    random_burst(180, PulseMinRst, PulseMaxRst, 180);
    settle();

    // shortest timeout, widest window; receiver holds off early on
    set_limits(16'd1, 16'd0, 16'hFFFF);
    hold_go <= 1'b1;
    random_burst(220, 16'd0, 16'hFFFF, 220);
    settle();

    // longest timeout, fully crossed limits
    set_limits(16'hFFFF, 16'hFFFF, 16'd0);
    random_burst(150, 16'hFFFF, 16'd0, 150);
    settle();

    // a stretch with no idling on either side
    t  = CfgW'($urandom_range(40, 2));
    lo = CfgW'($urandom_range(3000));
    hi = CfgW'(lo + $urandom_range(2000));
    set_limits(t, lo, hi);
    calm <= 1'b1;
    random_burst(260, lo, hi, 260);
    settle();
    calm <= 1'b0;

    // random limits, the sender pausing halfway until everything is back
    t  = CfgW'($urandom_range(30, 1));
    lo = CfgW'($urandom_range(65535));
    hi = CfgW'($urandom_range(65535));
    set_limits(t, lo, hi);
    random_burst(260, lo, hi, 130);
    settle();

    t  = CfgW'($urandom_range(60, 1));
    lo = CfgW'($urandom_range(2000));
    hi = CfgW'(lo + $urandom_range(4000));
    set_limits(t, lo, hi);
    random_burst(260, lo, hi, 260);
    settle();

    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### armed_servo_deadman_controller.f
rtl/asdc_pkg.sv
rtl/asdc_cfg_regs.sv
rtl/asdc_core.sv
rtl/armed_servo_deadman_controller.sv
sim/asdc_checker.sv
sim/tb.sv
